[sv/hxfr_pkg.sv]
package hxfr_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MODE_MASK   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BALL_MASK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_MASK = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CONF_LIMIT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POS_LIMIT   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CSUM  = 2'd1;
  localparam logic [1:0] ST_FIELD = 2'd2;
  localparam logic [1:0] ST_LINE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XOR,
    S_CHECK,
    S_EMIT,
    S_ALIGN
  } state_t;

  typedef struct packed {
    logic [7:0]  mode_mask;
    logic [7:0]  ball_mask;
    logic [7:0]  target_mask;
    logic [7:0]  conf_limit;
    logic [14:0] pos_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic load_byte;
    logic line_err;
    logic xor_step;
    logic eval;
    logic emit;
    logic shift;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic xor_last;
    logic reject;
    logic out_free;
    logic align_done;
  } dp_stat_t;

endpackage

[sv/hxfr_regs.sv]
module hxfr_regs
  import hxfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  cfg_regs_t               cfg_r;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_mask   <= 8'd48;
      cfg_r.ball_mask   <= 8'd1;
      cfg_r.target_mask <= 8'd2;
      cfg_r.conf_limit  <= 8'd100;
      cfg_r.pos_limit   <= 15'd1200;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE_MASK:   cfg_r.mode_mask   <= pwdata[7:0];
        REG_BALL_MASK:   cfg_r.ball_mask   <= pwdata[7:0];
        REG_TARGET_MASK: cfg_r.target_mask <= pwdata[7:0];
        REG_CONF_LIMIT:  cfg_r.conf_limit  <= pwdata[7:0];
        REG_POS_LIMIT:   cfg_r.pos_limit   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE_MASK:   prdata = {24'd0, cfg_r.mode_mask};
      REG_BALL_MASK:   prdata = {24'd0, cfg_r.ball_mask};
      REG_TARGET_MASK: prdata = {24'd0, cfg_r.target_mask};
      REG_CONF_LIMIT:  prdata = {24'd0, cfg_r.conf_limit};
      REG_POS_LIMIT:   prdata = {17'd0, cfg_r.pos_limit};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

[sv/hxfr_ctrl.sv]
module hxfr_ctrl
  import hxfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_line_error,
  output logic      in_ready,
  input  dp_stat_t  st,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_line_error) begin
            cmd.line_err = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.load_byte = 1'b1;
            if (st.frame_done) state_nxt = S_XOR;
          end
        end
      end
      S_XOR: begin
        cmd.xor_step = 1'b1;
        if (st.xor_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.eval  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.reject ? S_ALIGN : S_IDLE;
        end
      end
      S_ALIGN: begin
        cmd.shift = 1'b1;
        if (st.align_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/hxfr_dp.sv]
module hxfr_dp
  import hxfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           st,
  input  cfg_regs_t          cfg,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic [7:0]         out_seq_number,
  output logic [7:0]         out_flag_bits,
  output logic [7:0]         out_confidence,
  output logic signed [15:0] out_position,
  output logic signed [15:0] out_velocity,
  output logic signed [15:0] out_setpoint,
  output logic [31:0]        out_good_frames,
  output logic [31:0]        out_bad_events
);

  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] XOR_LAST  = IDX_W'(FRAME_BYTES - 2);

  logic [7:0]       store_r [FRAME_BYTES];
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       xor_r;
  logic [1:0]       stat_r;
  logic [31:0]      good_r, bad_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [7:0]       out_seq_r, out_flags_r, out_conf_r;
  logic [15:0]      out_pos_r, out_vel_r, out_set_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] align_cnt, align_fill;
  logic             align_hit, align_end;
  logic [7:0]       flags_m;
  logic             mode_ok, conf_ok, pos_bad, set_bad;
  logic [1:0]       eval_status;
  logic             out_free;

  function automatic logic out_of_limit(logic [15:0] v, logic [14:0] lim);
    logic signed [16:0] sv;
    logic signed [16:0] sl;
    sv = $signed({v[15], v});
    sl = $signed({2'b00, lim});
    return (sv < -sl) || (sv > sl);
  endfunction

  assign out_free = !out_valid_r || out_ready;

  // realign: one left shift per cycle, stop on a header pair or one byte left
  assign align_cnt  = fill_r - CNT_W'(1);
  assign align_hit  = (store_r[1] == SYNC_FIRST) && (store_r[2] == SYNC_SECOND) &&
                      (align_cnt >= CNT_W'(2));
  assign align_end  = (align_cnt == CNT_W'(1));
  assign align_fill = align_hit ? align_cnt :
                      align_end ? ((store_r[1] == SYNC_FIRST) ? CNT_W'(1) : CNT_W'(0)) :
                      align_cnt;

  assign flags_m = store_r[3] & cfg.mode_mask;
  assign mode_ok = (flags_m[7:4] != 4'd0) && (flags_m[7:4] <= 4'd3);
  assign conf_ok = store_r[4] <= cfg.conf_limit;
  assign pos_bad = ((store_r[3] & cfg.ball_mask) != 8'd0) &&
                   out_of_limit({store_r[6], store_r[5]}, cfg.pos_limit);
  assign set_bad = ((store_r[3] & cfg.target_mask) != 8'd0) &&
                   out_of_limit({store_r[10], store_r[9]}, cfg.pos_limit);

  always_comb begin
    if (xor_r != store_r[FRAME_BYTES-1]) begin
      eval_status = ST_CSUM;
    end else if (!mode_ok || !conf_ok || pos_bad || set_bad) begin
      eval_status = ST_FIELD;
    end else begin
      eval_status = ST_OK;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    wr_en    = 1'b0;
    wr_idx   = '0;
    if (cmd.line_err) begin
      fill_nxt = '0;
    end else if (cmd.load_byte) begin
      if (fill_r == CNT_W'(0)) begin
        if (in_rx_byte == SYNC_FIRST) begin
          wr_en    = 1'b1;
          fill_nxt = CNT_W'(1);
        end
      end else if (fill_r == CNT_W'(1)) begin
        if (in_rx_byte == SYNC_SECOND) begin
          wr_en    = 1'b1;
          wr_idx   = IDX_W'(1);
          fill_nxt = CNT_W'(2);
        end else if (in_rx_byte == SYNC_FIRST) begin
          wr_en = 1'b1;
        end else begin
          fill_nxt = '0;
        end
      end else begin
        wr_en = 1'b1;
        if (fill_r >= FILL_FULL) begin
          fill_nxt = CNT_W'(1);
        end else begin
          wr_idx   = fill_r[IDX_W-1:0];
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
    end else if (cmd.emit && (stat_r == ST_OK)) begin
      fill_nxt = '0;
    end else if (cmd.shift) begin
      fill_nxt = align_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < FRAME_BYTES - 1; k++) begin
        store_r[k] <= store_r[k+1];
      end
    end else if (wr_en) begin
      store_r[wr_idx] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      xor_r <= 8'd0;
      idx_r <= '0;
    end else if (cmd.xor_step) begin
      xor_r <= xor_r ^ store_r[idx_r];
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.line_err) begin
      stat_r <= ST_LINE;
    end else if (cmd.eval) begin
      stat_r <= eval_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      good_r      <= 32'd0;
      bad_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (stat_r == ST_OK) begin
          good_r <= good_r + 32'd1;
        end else begin
          bad_r <= bad_r + 32'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= stat_r;
      if (stat_r == ST_OK) begin
        out_seq_r   <= store_r[2];
        out_flags_r <= store_r[3];
        out_conf_r  <= store_r[4];
        out_pos_r   <= {store_r[6], store_r[5]};
        out_vel_r   <= {store_r[8], store_r[7]};
        out_set_r   <= {store_r[10], store_r[9]};
      end else begin
        out_seq_r   <= 8'd0;
        out_flags_r <= 8'd0;
        out_conf_r  <= 8'd0;
        out_pos_r   <= 16'd0;
        out_vel_r   <= 16'd0;
        out_set_r   <= 16'd0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = out_status_r;
  assign out_seq_number   = out_seq_r;
  assign out_flag_bits    = out_flags_r;
  assign out_confidence   = out_conf_r;
  assign out_position     = $signed(out_pos_r);
  assign out_velocity     = $signed(out_vel_r);
  assign out_setpoint     = $signed(out_set_r);
  assign out_good_frames  = good_r;
  assign out_bad_events   = bad_r;

  assign st.frame_done = (fill_r == FILL_LAST);
  assign st.xor_last   = (idx_r == XOR_LAST);
  assign st.reject     = (stat_r == ST_CSUM) || (stat_r == ST_FIELD);
  assign st.out_free   = out_free;
  assign st.align_done = align_hit || align_end;

endmodule

[sv/header_xor_frame_receiver_core.sv]
// A byte that does not complete a frame leaves the core in S_IDLE; a line error goes
// to S_EMIT. The byte that completes a frame is followed by an XOR pass over the stored
// bytes (S_XOR), a check state (S_CHECK) and S_EMIT; S_EMIT waits until the output
// is free. After a reject, realignment shifts the buffer one byte per cycle (S_ALIGN).
// Synchronous active-low reset clears fill count, counters, output valid and registers
// to their defaults; the buffer is not cleared.
module header_xor_frame_receiver_core
  import hxfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_line_error,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic [7:0]         out_seq_number,
  output logic [7:0]         out_flag_bits,
  output logic [7:0]         out_confidence,
  output logic signed [15:0] out_position,
  output logic signed [15:0] out_velocity,
  output logic signed [15:0] out_setpoint,
  output logic [31:0]        out_good_frames,
  output logic [31:0]        out_bad_events,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_regs_t cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  st;

  hxfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hxfr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_line_error (in_line_error),
    .in_ready      (in_ready),
    .st            (st),
    .cmd           (cmd)
  );

  hxfr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg              (cfg),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_seq_number   (out_seq_number),
    .out_flag_bits    (out_flag_bits),
    .out_confidence   (out_confidence),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .out_setpoint     (out_setpoint),
    .out_good_frames  (out_good_frames),
    .out_bad_events   (out_bad_events)
  );

endmodule

[sim/tb_top.sv]
module tb_top;
  import hxfr_pkg::*;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  seq_number;
    logic [7:0]  flag_bits;
    logic [7:0]  confidence;
    logic [15:0] position;
    logic [15:0] velocity;
    logic [15:0] setpoint;
    logic [31:0] good_frames;
    logic [31:0] bad_events;
  } frame_result_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } rx_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = '0;
  logic               in_line_error = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_frame_status;
  logic [7:0]         out_seq_number;
  logic [7:0]         out_flag_bits;
  logic [7:0]         out_confidence;
  logic signed [15:0] out_position;
  logic signed [15:0] out_velocity;
  logic signed [15:0] out_setpoint;
  logic [31:0]        out_good_frames;
  logic [31:0]        out_bad_events;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state
  logic [7:0]  frame_buf [FRAME_BYTES];
  int          fill_cnt = 0;
  logic [31:0] good_total = '0;
  logic [31:0] bad_total = '0;
  logic [7:0]  cfg_mode_mask = 8'd48;
  logic [7:0]  cfg_ball_mask = 8'd1;
  logic [7:0]  cfg_target_mask = 8'd2;
  logic [7:0]  cfg_conf_limit = 8'd100;
  logic [14:0] cfg_pos_limit = 15'd1200;

  frame_result_t expect_q[$];
  rx_item_t      tx_q[$];
  rx_item_t      nxt;
  frame_result_t seen;
  frame_result_t want;
  int            items_queued = 0;
  int            bad_checks = 0;
  logic          no_idle = 1'b0;
  logic          hold_armed = 1'b0;
  logic          hold_used;
  int            rx_hold_cnt;

  header_xor_frame_receiver_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_line_error    (in_line_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_seq_number   (out_seq_number),
    .out_flag_bits    (out_flag_bits),
    .out_confidence   (out_confidence),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .out_setpoint     (out_setpoint),
    .out_good_frames  (out_good_frames),
    .out_bad_events   (out_bad_events),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  function automatic logic beyond_limit(input logic [15:0] v);
    int val;
    int lim;
    val = int'($signed(v));
    lim = int'(cfg_pos_limit);
    return (val < -lim) || (val > lim);
  endfunction

  function automatic void predict_rx(input logic [7:0] b, input logic lerr);
    frame_result_t r;
    logic [7:0]    x;
    logic [7:0]    masked;
    logic [3:0]    mode;
    logic [1:0]    st;
    logic          found;
    int            k;
    int            s;
    r = '0;
    if (lerr) begin
      fill_cnt = 0;
      bad_total++;
      r.frame_status = ST_LINE;
      r.good_frames = good_total;
      r.bad_events = bad_total;
      expect_q.push_back(r);
      return;
    end
    if (fill_cnt == 0) begin
      if (b == SYNC_FIRST) begin
        frame_buf[0] = b;
        fill_cnt = 1;
      end
      return;
    end
    if (fill_cnt == 1) begin
      if (b == SYNC_SECOND) begin
        frame_buf[1] = b;
        fill_cnt = 2;
      end else if (b != SYNC_FIRST) begin
        fill_cnt = 0;
      end
      return;
    end
    frame_buf[fill_cnt] = b;
    fill_cnt++;
    if (fill_cnt < FRAME_BYTES) return;

    x = '0;
    for (k = 0; k < FRAME_BYTES - 1; k++) x ^= frame_buf[k];
    masked = frame_buf[3] & cfg_mode_mask;
    mode = masked[7:4];
    if (x != frame_buf[FRAME_BYTES-1]) st = ST_CSUM;
    else if (mode < 4'd1 || mode > 4'd3 || frame_buf[4] > cfg_conf_limit) st = ST_FIELD;
    else if ((frame_buf[3] & cfg_ball_mask) != 0 &&
             beyond_limit({frame_buf[6], frame_buf[5]})) st = ST_FIELD;
    else if ((frame_buf[3] & cfg_target_mask) != 0 &&
             beyond_limit({frame_buf[10], frame_buf[9]})) st = ST_FIELD;
    else st = ST_OK;

    if (st == ST_OK) begin
      good_total++;
      r.seq_number = frame_buf[2];
      r.flag_bits  = frame_buf[3];
      r.confidence = frame_buf[4];
      r.position   = {frame_buf[6], frame_buf[5]};
      r.velocity   = {frame_buf[8], frame_buf[7]};
      r.setpoint   = {frame_buf[10], frame_buf[9]};
      fill_cnt = 0;
    end else begin
      bad_total++;
      // resync on the earliest later header, else a trailing first header byte
      found = 1'b0;
      for (s = 1; s + 1 < FRAME_BYTES && !found; s++) begin
        if (frame_buf[s] == SYNC_FIRST && frame_buf[s+1] == SYNC_SECOND) begin
          for (k = 0; k < FRAME_BYTES - s; k++) frame_buf[k] = frame_buf[s+k];
          fill_cnt = FRAME_BYTES - s;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (frame_buf[FRAME_BYTES-1] == SYNC_FIRST) begin
          frame_buf[0] = SYNC_FIRST;
          fill_cnt = 1;
        end else begin
          fill_cnt = 0;
        end
      end
    end
    r.frame_status = st;
    r.good_frames = good_total;
    r.bad_events = bad_total;
    expect_q.push_back(r);
  endfunction

  function automatic string show_result(input frame_result_t r);
    return $sformatf("st=%0d seq=%h flg=%h conf=%h pos=%h vel=%h sp=%h good=%0d bad=%0d",
                     r.frame_status, r.seq_number, r.flag_bits, r.confidence, r.position,
                     r.velocity, r.setpoint, r.good_frames, r.bad_events);
  endfunction

  function automatic void push_item(input logic [7:0] b, input logic e);
    tx_q.push_back({b, e});
    items_queued++;
  endfunction

  function automatic void queue_frame(input logic [7:0] seq, input logic [7:0] flags,
                                      input logic [7:0] conf, input logic [15:0] pos,
                                      input logic [15:0] vel, input logic [15:0] setp,
                                      input int sync_at, input logic [7:0] csum_flip,
                                      input logic trail_aa);
    logic [7:0] f [FRAME_BYTES];
    logic [7:0] x;
    int         k;
    f[0] = SYNC_FIRST;
    f[1] = SYNC_SECOND;
    f[2] = seq;
    f[3] = flags;
    f[4] = conf;
    f[5] = pos[7:0];
    f[6] = pos[15:8];
    f[7] = vel[7:0];
    f[8] = vel[15:8];
    f[9] = setp[7:0];
    f[10] = setp[15:8];
    for (k = 11; k < FRAME_BYTES - 1; k++) f[k] = 8'($urandom);
    if (sync_at > 1) begin
      f[sync_at] = SYNC_FIRST;
      f[sync_at+1] = SYNC_SECOND;
    end
    x = '0;
    for (k = 0; k < FRAME_BYTES - 1; k++) x ^= f[k];
    f[FRAME_BYTES-1] = trail_aa ? SYNC_FIRST : (x ^ csum_flip);
    for (k = 0; k < FRAME_BYTES; k++) push_item(f[k], 1'b0);
  endfunction

  function automatic logic [15:0] pick_pair();
    int lim;
    lim = int'(cfg_pos_limit);
    case ($urandom_range(7))
      0: return 16'($urandom);
      1: return 16'(lim);
      2: return 16'(-lim);
      3: return 16'(lim + 1);
      4: return 16'(-lim - 1);
      5: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'(int'($urandom_range(2 * lim)) - lim);
    endcase
  endfunction

  task automatic queue_random(input int n);
    int         stop_at;
    int         r;
    int         k;
    int         cut;
    int         sync_at;
    logic [7:0] flags;
    logic [7:0] conf;
    logic [7:0] flip;
    @(negedge clk);
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        cut = $urandom_range(1, 4);
        for (k = 0; k < cut; k++)
          push_item($urandom_range(3) == 0 ? SYNC_FIRST : 8'($urandom),
                    $urandom_range(9) == 0);
      end else if (r < 13) begin
        push_item(8'($urandom), 1'b1);
      end else if (r < 21) begin
        // truncated frame, often cut short by a line error
        push_item(SYNC_FIRST, 1'b0);
        push_item(SYNC_SECOND, 1'b0);
        cut = $urandom_range(0, FRAME_BYTES - 3);
        for (k = 0; k < cut; k++) push_item(8'($urandom), 1'b0);
        if ($urandom_range(1)) push_item(8'($urandom), 1'b1);
      end else begin
        if ($urandom_range(9) == 0) push_item(SYNC_FIRST, 1'b0);
        flags = 8'($urandom);
        if ($urandom_range(3) != 0) flags[5:4] = 2'($urandom_range(1, 3));
        conf = ($urandom_range(3) != 0) ? 8'($urandom_range(cfg_conf_limit)) : 8'($urandom);
        sync_at = ($urandom_range(9) == 0) ? $urandom_range(2, FRAME_BYTES - 3) : 0;
        k = $urandom_range(19);
        flip = (k < 2) ? 8'($urandom_range(1, 255)) : 8'd0;
        queue_frame(8'($urandom), flags, conf, pick_pair(), 16'($urandom), pick_pair(),
                    sync_at, flip, k == 2);
      end
    end
  endtask

  task automatic drain();
    while (tx_q.size() != 0 || in_valid || expect_q.size() != 0) @(negedge clk);
    repeat (2 * FRAME_BYTES + 8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE_MASK:   cfg_mode_mask = val[7:0];
      REG_BALL_MASK:   cfg_ball_mask = val[7:0];
      REG_TARGET_MASK: cfg_target_mask = val[7:0];
      REG_CONF_LIMIT:  cfg_conf_limit = val[7:0];
      REG_POS_LIMIT:   cfg_pos_limit = val[14:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [31:0] mode_m, input logic [31:0] ball_m,
                         input logic [31:0] target_m, input logic [31:0] conf_l,
                         input logic [31:0] pos_l);
    cfg_write(REG_MODE_MASK, mode_m);
    cfg_write(REG_BALL_MASK, ball_m);
    cfg_write(REG_TARGET_MASK, target_m);
    cfg_write(REG_CONF_LIMIT, conf_l);
    cfg_write(REG_POS_LIMIT, pos_l);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_rx(in_rx_byte, in_line_error);
      if (!in_valid || in_ready) begin
        if (tx_q.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
          nxt = tx_q.pop_front();
          in_valid      <= 1'b1;
          in_rx_byte    <= nxt.rx_byte;
          in_line_error <= nxt.line_error;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_cnt <= 0;
      hold_used   <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      rx_hold_cnt <= 400;
      hold_used   <= 1'b1;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (rx_hold_cnt == 0) && (no_idle || $urandom_range(99) >= 10);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = {out_frame_status, out_seq_number, out_flag_bits, out_confidence, out_position,
              out_velocity, out_setpoint, out_good_frames, out_bad_events};
      if (expect_q.size() == 0) begin
        bad_checks++;
        if (bad_checks <= 10) $display("unexpected result: %s", show_result(seen));
      end else begin
        want = expect_q.pop_front();
        if (seen !== want) begin
          bad_checks++;
          if (bad_checks <= 10)
            $display("result mismatch\n  expected %s\n  actual   %s",
                     show_result(want), show_result(seen));
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: accepted frame at the limits, repeated header byte then line error,
    // checksum reject with a header pair inside the frame
    queue_frame(8'hFF, 8'h13, 8'd100, 16'd1200, 16'h8000, 16'hFB50, 0, 8'h00, 1'b0);
    push_item(SYNC_FIRST, 1'b0);
    push_item(SYNC_FIRST, 1'b0);
    push_item(SYNC_SECOND, 1'b0);
    push_item(8'hFF, 1'b1);
    queue_frame(8'h00, 8'h00, SYNC_FIRST, {8'h00, SYNC_SECOND}, 16'h7FFF, 16'h0000, 0,
                8'hFF, 1'b0);
    queue_random(150);
    drain();

    cfg_all(32'hFF, 32'hFF, 32'hFF, 32'hFF, 32'h7FFF);
    no_idle <= 1'b1;
    queue_random(150);
    drain();
    no_idle <= 1'b0;

    cfg_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_random(100);
    drain();

    cfg_all($urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(200);
    hold_armed <= 1'b1;
    drain();

    cfg_all(32'd48, 32'd1, 32'd2, 32'd100, 32'd1200);
    queue_random(250);
    drain();

    if (bad_checks == 0 && expect_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
